// ===== design/block_address_coverage_counter_defines.svh =====
// Assertion macros for the block address coverage counter checker.
// Expects signals named clk and rst_n in the scope where a macro is used.
`ifndef BLOCK_ADDRESS_COVERAGE_COUNTER_DEFINES_SVH
`define BLOCK_ADDRESS_COVERAGE_COUNTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BACC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BACC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/bacc_pkg.sv =====
// Shared types and constants for the block address coverage counter.
// No dependencies; imported by every module of the block.
`default_nettype none

package bacc_pkg;

    localparam int ADDR_W          = 64;
    localparam int COUNT_W         = 8;
    localparam int OUT_IDX_W       = 10;
    localparam int MAX_ENTRIES_DEF = 1024;

    typedef enum logic [1:0] {
        STATUS_KNOWN = 2'd0,
        STATUS_NEW   = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    // One beat moving down the cell chain. STATUS_FULL means still unresolved.
    typedef struct packed {
        logic                valid;
        logic [ADDR_W-1:0]   addr;
        logic [COUNT_W-1:0]  count;
        status_t             status;
    } beat_t;

endpackage

`default_nettype wire

// ===== design/bacc_cell.sv =====
// One table entry of the coverage counter chain: address, valid bit, counter.
// Depends on bacc_pkg.
`default_nettype none

module bacc_cell #(
    parameter int IDX_W    = 10,
    parameter int CELL_IDX = 0
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            advance,
    input  wire bacc_pkg::beat_t beat_in,
    input  wire logic [IDX_W-1:0] idx_in,
    output bacc_pkg::beat_t      beat_out,
    output logic [IDX_W-1:0]     idx_out
);
    import bacc_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic               entry_valid_reg;
    logic               entry_valid_next;
    logic [ADDR_W-1:0]  entry_addr_reg;
    logic [ADDR_W-1:0]  entry_addr_next;
    logic [COUNT_W-1:0] entry_count_reg;
    logic [COUNT_W-1:0] entry_count_next;
    beat_t              beat_reg;
    beat_t              beat_next;
    logic [IDX_W-1:0]   idx_reg;
    logic [IDX_W-1:0]   idx_next;

    logic               pending;
    logic               match;
    logic               claim;
    logic [COUNT_W-1:0] count_inc;

    always_comb
    begin
        pending   = beat_in.valid && (beat_in.status == STATUS_FULL);
        match     = pending && entry_valid_reg && (entry_addr_reg == beat_in.addr);
        claim     = pending && !entry_valid_reg;
        count_inc = entry_count_reg + COUNT_W'(1);

        beat_next        = beat_in;
        idx_next         = idx_in;
        entry_valid_next = entry_valid_reg;
        entry_addr_next  = entry_addr_reg;
        entry_count_next = entry_count_reg;

        if (match)
        begin
            // bump the stored counter and resolve the beat here
            beat_next.count  = count_inc;
            beat_next.status = STATUS_KNOWN;
            idx_next         = MY_IDX;
            entry_count_next = count_inc;
        end
        else if (claim)
        begin
            // first free entry: record the address, count starts at one
            beat_next.count  = COUNT_W'(1);
            beat_next.status = STATUS_NEW;
            idx_next         = MY_IDX;
            entry_valid_next = 1'b1;
            entry_addr_next  = beat_in.addr;
            entry_count_next = COUNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= 1'b0;
            beat_reg        <= '0;
        end
        else if (advance)
        begin
            entry_valid_reg <= entry_valid_next;
            beat_reg        <= beat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            entry_addr_reg  <= entry_addr_next;
            entry_count_reg <= entry_count_next;
            idx_reg         <= idx_next;
        end
    end

    assign beat_out = beat_reg;
    assign idx_out  = idx_reg;

endmodule

`default_nettype wire

// ===== design/bacc_out.sv =====
// Output stage: resolves dropped beats against the last hit and holds the result.
// Depends on bacc_pkg.
`default_nettype none

module bacc_out #(
    parameter int IDX_W = 10
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             advance,
    input  wire bacc_pkg::beat_t  beat_in,
    input  wire logic [IDX_W-1:0] idx_in,
    output logic                  out_valid,
    output logic [bacc_pkg::OUT_IDX_W-1:0] block_index,
    output logic [bacc_pkg::COUNT_W-1:0]   hit_count,
    output logic [1:0]            status
);
    import bacc_pkg::*;

    logic                 out_valid_reg;
    logic [OUT_IDX_W-1:0] out_index_reg;
    logic [OUT_IDX_W-1:0] out_index_next;
    logic [COUNT_W-1:0]   out_count_reg;
    logic [COUNT_W-1:0]   out_count_next;
    status_t              out_status_reg;
    logic [IDX_W-1:0]     last_idx_reg;
    logic [IDX_W-1:0]     last_idx_next;
    logic [COUNT_W-1:0]   last_count_reg;
    logic [COUNT_W-1:0]   last_count_next;

    always_comb
    begin
        last_idx_next   = last_idx_reg;
        last_count_next = last_count_reg;
        if (beat_in.valid && (beat_in.status != STATUS_FULL))
        begin
            last_idx_next   = idx_in;
            last_count_next = beat_in.count;
        end
        // a dropped beat reports the last resolved index, which the update leaves alone
        out_index_next = OUT_IDX_W'(last_idx_next);
        out_count_next = last_count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            last_idx_reg   <= '0;
            last_count_reg <= '0;
        end
        else if (advance)
        begin
            out_valid_reg  <= beat_in.valid;
            last_idx_reg   <= last_idx_next;
            last_count_reg <= last_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && beat_in.valid)
        begin
            out_index_reg  <= out_index_next;
            out_count_reg  <= out_count_next;
            out_status_reg <= beat_in.status;
        end
    end

    assign out_valid   = out_valid_reg;
    assign block_index = out_index_reg;
    assign hit_count   = out_count_reg;
    assign status      = out_status_reg;

endmodule

`default_nettype wire

// ===== design/block_address_coverage_counter.sv =====
// Block address coverage counter. Each input beat carries one basic-block
// address; the block returns one beat per input with the dense index of that
// address, its 8-bit hit counter after the increment (wrapping 255 to 0) and a
// status: known address, new entry added, or table full and event dropped (the
// dropped beat repeats the last resolved index and its count). The table is a chain
// of MAX_ENTRIES cells, one entry each; while the chain advances a beat walks it
// one cell per cycle; the first cell holding its address, or the first empty
// cell, resolves it. A beat enters every cycle unless the output stalls, and
// a result leaves through the cell chain and then the output register. Beats
// never pass each other, so an entry added by one beat is seen by the next.
// The whole chain holds while a finished result is stalled at the output.
// Depends on bacc_pkg, bacc_cell and bacc_out.
`default_nettype none

module block_address_coverage_counter #(
    parameter int MAX_ENTRIES = bacc_pkg::MAX_ENTRIES_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [bacc_pkg::ADDR_W-1:0]  block_address,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic [bacc_pkg::OUT_IDX_W-1:0]    block_index,
    output logic [bacc_pkg::COUNT_W-1:0]      hit_count,
    output logic [1:0]                        status
);
    import bacc_pkg::*;

    localparam int IDX_W = $clog2(MAX_ENTRIES);

    beat_t            beat_chain [MAX_ENTRIES+1];
    logic [IDX_W-1:0] idx_chain  [MAX_ENTRIES+1];
    logic             advance;

    // Advance the chain whenever the output register is free or being taken.
    assign advance  = !out_valid || !out_stall;
    assign in_stall = !advance;

    // Launch an unresolved beat into the first cell.
    always_comb
    begin
        beat_chain[0].valid  = in_valid;
        beat_chain[0].addr   = block_address;
        beat_chain[0].count  = '0;
        beat_chain[0].status = STATUS_FULL;
        idx_chain[0]         = '0;
    end

    for (genvar g = 0; g < MAX_ENTRIES; g++)
    begin : g_cell
        bacc_cell #(
            .IDX_W    (IDX_W),
            .CELL_IDX (g)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .advance  (advance),
            .beat_in  (beat_chain[g]),
            .idx_in   (idx_chain[g]),
            .beat_out (beat_chain[g+1]),
            .idx_out  (idx_chain[g+1])
        );
    end

    // A beat still unresolved past the last cell is a drop on a full table.
    bacc_out #(
        .IDX_W (IDX_W)
    ) u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .beat_in     (beat_chain[MAX_ENTRIES]),
        .idx_in      (idx_chain[MAX_ENTRIES]),
        .out_valid   (out_valid),
        .block_index (block_index),
        .hit_count   (hit_count),
        .status      (status)
    );

endmodule

`default_nettype wire

// ===== design/bacc_checker.sv =====
// Port-level checks for the block address coverage counter, bound to the top.
// Depends on bacc_pkg and block_address_coverage_counter_defines.svh.
`default_nettype none
`include "block_address_coverage_counter_defines.svh"

module bacc_checker (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         in_stall,
    input wire logic                         out_valid,
    input wire logic                         out_stall,
    input wire logic [bacc_pkg::OUT_IDX_W-1:0] block_index,
    input wire logic [bacc_pkg::COUNT_W-1:0] hit_count,
    input wire logic [1:0]                   status
);
    import bacc_pkg::*;

    // input backpressure comes only from a stalled result
    `BACC_ASSERT_IMP(a_stall_cause, in_stall, out_valid && out_stall,
        "input stalled without output stall")
    // a freshly added entry has been counted exactly once
    `BACC_ASSERT_IMP(a_new_count, out_valid && (status == STATUS_NEW), hit_count == 8'd1,
        "new entry count not one")
    // a stalled result holds
    `BACC_ASSERT_NXT(a_out_hold, out_valid && out_stall,
        out_valid && $stable(block_index) && $stable(hit_count) && $stable(status),
        "stalled result changed")
    // a drop means the table is full, so the next result cannot add an entry
    `BACC_ASSERT_NXT(a_drop_index, out_valid && !out_stall && (status == STATUS_FULL),
        !(out_valid && (status == STATUS_NEW)), "new entry after table full")

endmodule

bind block_address_coverage_counter bacc_checker u_bacc_checker (.*);

`default_nettype wire
